FILE: sv/double_scale_by_power_of_two_defines.svh
// Assertion macros for the scaling block.
`ifndef DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`define DOUBLE_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`ifndef SYNTH
`define DSP2_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DSP2_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define DSP2_ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define DSP2_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

FILE: sv/dsp2_pkg.sv
// ----------------------------------------------------------------------------
// dsp2_pkg
// Types and constants shared by the scaling block.
// ----------------------------------------------------------------------------
`default_nettype none
package dsp2_pkg;
  localparam int unsigned FracW = 52;
  localparam logic [10:0] ExpMax = 11'h7ff;
  localparam logic signed [31:0] TinyScale = -32'sd50000;
  localparam logic signed [13:0] UflowLim = -14'sd53;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_ZERO_SGN,
    CLS_SCALE
  } cls_t;

  // Classified beat passed from front to back.
  typedef struct packed {
    cls_t              cls;
    logic              sign;
    logic [63:0]       pass_bits;
    logic [52:0]       sig;
    logic signed [33:0] adj;
  } item_t;

  function automatic logic [5:0] lzc52(input logic [51:0] f);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && f[i]) begin
        found = 1'b1;
        n = 6'(51 - i);
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

FILE: sv/dsp2_front.sv
// ----------------------------------------------------------------------------
// dsp2_front
// Classifies the operand, normalises subnormals and forms the exponent sum.
// ----------------------------------------------------------------------------
`default_nettype none
module dsp2_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [63:0]        in_value_bits,
  input  wire logic signed [31:0] in_scale,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output dsp2_pkg::item_t         f_item,
  output logic                    f_valid,
  input  wire logic               f_ready
);
  import dsp2_pkg::*;

  item_t item_r, item_nxt;
  logic  valid_r;
  logic [10:0] e;
  logic [51:0] f;
  logic [5:0]  lz;

  assign in_ready = !valid_r || f_ready;
  assign f_valid  = valid_r;
  assign f_item   = item_r;

  always_comb begin
    e  = in_value_bits[62:52];
    f  = in_value_bits[51:0];
    lz = lzc52(f);
    item_nxt           = '0;
    item_nxt.sign      = in_value_bits[63];
    item_nxt.pass_bits = in_value_bits;
    if (e == 11'd0) begin
      if (f == '0) begin
        item_nxt.cls = CLS_PASS;
      end else if (in_scale < TinyScale) begin
        item_nxt.cls = CLS_ZERO_SGN;
      end else begin
        item_nxt.cls = CLS_SCALE;
        item_nxt.sig = {f, 1'b0} << lz;
        item_nxt.adj = 34'(in_scale) - 34'(lz);
      end
    end else if (e == ExpMax) begin
      item_nxt.cls = CLS_PASS;
      if (f != '0) item_nxt.pass_bits[51] = 1'b1;
    end else begin
      item_nxt.cls = CLS_SCALE;
      item_nxt.sig = {1'b1, f};
      item_nxt.adj = 34'(in_scale) + 34'(e);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= item_nxt;
  end
endmodule
`default_nettype wire

FILE: sv/dsp2_queue.sv
// ----------------------------------------------------------------------------
// dsp2_queue
// Two-entry queue that decouples front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module dsp2_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  dsp2_pkg::item_t w_item,
  input  wire logic       w_valid,
  output logic            w_ready,
  output dsp2_pkg::item_t r_item,
  output logic            r_valid,
  input  wire logic       r_ready
);
  import dsp2_pkg::*;

  item_t mem_r [2];
  logic  wp_r, rp_r;
  logic [1:0] cnt_r;
  logic  wr, rd;

  assign w_ready = cnt_r != 2'd2;
  assign r_valid = cnt_r != 2'd0;
  assign r_item  = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= w_item;
  end
endmodule
`default_nettype wire

FILE: sv/dsp2_back.sv
// ----------------------------------------------------------------------------
// dsp2_back
// Packs the result: exponent replacement, saturation and rounded denormalising.
// ----------------------------------------------------------------------------
`default_nettype none
module dsp2_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  dsp2_pkg::item_t q_item,
  input  wire logic       q_valid,
  output logic            q_ready,
  output logic [63:0]     out_result_bits,
  output logic            out_valid,
  input  wire logic       out_ready
);
  import dsp2_pkg::*;

  logic [63:0] res_r, res_nxt;
  logic        valid_r;
  logic [5:0]  sh;
  logic [52:0] kept;
  // One bit wider than the significand so that the half point of a 54-bit
  // shift is still representable.
  logic [53:0] rem, half, mask;

  assign q_ready         = !valid_r || out_ready;
  assign out_valid       = valid_r;
  assign out_result_bits = res_r;

  always_comb begin
    sh   = 6'(34'sd1 - q_item.adj);
    kept = q_item.sig >> sh;
    mask = (54'd1 << sh) - 54'd1;
    rem  = {1'b0, q_item.sig} & mask;
    half = 54'd1 << (sh - 6'd1);
    res_nxt = {q_item.sign, 63'd0};
    case (q_item.cls)
      CLS_PASS: res_nxt = q_item.pass_bits;
      CLS_ZERO_SGN: res_nxt = {q_item.sign, 63'd0};
      CLS_SCALE: begin
        if (q_item.adj >= 34'sd2047) begin
          res_nxt = {q_item.sign, ExpMax, 52'd0};
        end else if (q_item.adj > 34'sd0) begin
          res_nxt = {q_item.sign, q_item.adj[10:0], q_item.sig[51:0]};
        end else if (q_item.adj < 34'(UflowLim)) begin
          res_nxt = {q_item.sign, 63'd0};
        end else begin
          if (rem > half || (rem == half && kept[0])) kept = kept + 53'd1;
          res_nxt = {q_item.sign, 10'd0, kept};
        end
      end
      default: res_nxt = {q_item.sign, 63'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

FILE: sv/double_scale_by_power_of_two.sv
// Path: an accepted input beat goes through the front register, a queue entry
// and the output register to its result beat, held back while the output stalls.
// Throughput: one beat a cycle unless the output stalls; front and back are each one register plus logic.
// Reset: synchronous active-low rst_n empties every stage; payload is not reset.
// ----------------------------------------------------------------------------
// double_scale_by_power_of_two
// Multiplies an IEEE-754 double by two to a signed integer power (scalbn).
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_scale_by_power_of_two_defines.svh"
module double_scale_by_power_of_two (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [63:0]        in_value_bits,
  input  wire logic signed [31:0] in_scale,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic [63:0]             out_result_bits,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import dsp2_pkg::*;

  // The front stage classifies each beat: specials pass through (NaNs quieted),
  // tiny-scaled subnormals go to signed zero, and other values get a normalised
  // significand and the wide exponent sum, so the back stage only packs the answer.
  item_t f_item, q_item;
  logic  f_valid, f_ready, q_valid, q_ready;

  dsp2_front u_front (
    .clk, .rst_n, .in_value_bits, .in_scale, .in_valid, .in_ready,
    .f_item, .f_valid, .f_ready
  );

  // A short queue lets the front keep taking beats while the back waits.
  dsp2_queue u_queue (
    .clk, .rst_n, .w_item(f_item), .w_valid(f_valid), .w_ready(f_ready),
    .r_item(q_item), .r_valid(q_valid), .r_ready(q_ready)
  );

  dsp2_back u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_ready,
    .out_result_bits, .out_valid, .out_ready
  );

  // A stalled result beat must keep its data.
  `DSP2_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(out_result_bits), "result changed while stalled")
  // A normalised significand always carries its leading one.
  `DSP2_ASSERT_IMPL(a_sig_norm, clk, rst_n, (q_valid && q_item.cls == CLS_SCALE) |-> q_item.sig[52], "unnormalised significand")
endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Testbench for double_scale_by_power_of_two
// Drives operand beats (value bits and a signed power of two) through the
// valid/ready handshake, predicts each result with a local model of the
// bit-level scaling and checks result beats in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

// Keeps the queue of predicted result patterns and scores result beats.
class scale_scoreboard;
  logic [63:0] pending_results[$];
  int unsigned mismatches;
  int unsigned errors;

  function new();
    mismatches = 0;
    errors = 0;
  endfunction

  // Bit-level scaling by a power of two, as the block is meant to do it.
  static function logic [63:0] scale_value(logic [63:0] bits, logic signed [31:0] pw);
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] sig;
    longint      e;
    longint      adj;
    int          sh;
    logic [52:0] kept;
    logic [53:0] rem;
    logic [53:0] half;
    sgn = bits[63];
    ex = bits[62:52];
    fr = bits[51:0];
    if (ex == 11'd0) begin
      if (fr == 52'd0) return bits;
      if (pw < dsp2_pkg::TinyScale) return {sgn, 63'd0};
      sig = {1'b0, fr};
      e = 1;
      while (!sig[52]) begin
        sig = sig << 1;
        e--;
      end
    end else if (ex == dsp2_pkg::ExpMax) begin
      if (fr != 52'd0) return bits | (64'd1 << 51);
      return bits;
    end else begin
      sig = {1'b1, fr};
      e = ex;
    end
    adj = e + longint'(pw);
    if (adj > 0 && adj < 2047) return {sgn, adj[10:0], sig[51:0]};
    if (adj >= 2047) return {sgn, dsp2_pkg::ExpMax, 52'd0};
    if (adj < -53) return {sgn, 63'd0};
    sh = int'(1 - adj);
    kept = sig >> sh;
    rem = {1'b0, sig} & ((54'd1 << sh) - 54'd1);
    half = 54'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 53'd1;
    return {sgn, 11'd0, 52'd0} | {11'd0, kept};
  endfunction

  function void note_operands(logic [63:0] bits, logic signed [31:0] pw);
    pending_results.push_back(scale_value(bits, pw));
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] want;
    if (pending_results.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending_results.pop_front();
    if (want !== got) begin
      errors++;
      if (mismatches++ < 10) $display("result mismatch: expected %h, got %h", want, got);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBeats = 1530;
  localparam int unsigned CycleLimit = 400000;

  logic               clk;
  logic               rst_n;
  logic [63:0]        in_value_bits;
  logic signed [31:0] in_scale;
  logic               in_valid;
  logic               in_ready;
  logic [63:0]        out_result_bits;
  logic               out_valid;
  logic               out_ready;

  scale_scoreboard board;
  int unsigned cycle_count;
  // Idling is switched off for a stretch in the middle of the run.
  bit          steady;
  // Set while the receiver is made to hold off for a long stretch.
  bit          hold_off;
  bit          stim_done;

  double_scale_by_power_of_two dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value_bits   (in_value_bits),
    .in_scale        (in_scale),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_result_bits (out_result_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver side: ready drops at random about a third of the time, or for a
  // long stretch while hold_off is set. Result beats are scored as accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_result_bits);
      if (hold_off) out_ready <= 1'b0;
      else if (steady) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 34);
    end
  end

  // Sends one operand beat, with an optional random gap before it, and waits
  // until the block takes it. The prediction is noted at the accepting edge.
  // Valid is only lowered when an idle cycle follows, so back-to-back beats
  // keep it high without a second assignment in the same step.
  task automatic send_beat(logic [63:0] bits, logic signed [31:0] pw);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_value_bits <= bits;
    in_scale      <= pw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_operands(bits, pw);
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Random value bits, weighted towards the interesting classes of double.
  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: r[62:52] = 11'd0;                                     // subnormal or zero
      1: r[62:52] = dsp2_pkg::ExpMax;                          // infinity or NaN
      2: r[51:0]  = ($urandom_range(1) != 0) ? 52'd0 : r[51:0];
      3: r[62:52] = 11'($urandom_range(3)) + 11'd1;            // near the bottom
      4: r[62:52] = 11'd2046 - 11'($urandom_range(3));         // near the top
      default: ;
    endcase
    return r;
  endfunction

  // Random power, mostly small enough to land near the exponent boundaries.
  function automatic logic signed [31:0] pick_scale();
    case ($urandom_range(7))
      0: return $urandom;
      1: return -32'sd50000 - 32'sd2 + 32'($urandom_range(4));
      2: return 32'($urandom_range(4400)) - 32'sd2200;
      default: return 32'($urandom_range(140)) - 32'sd70;
    endcase
  endfunction

  initial begin
    logic [63:0] v;
    board         = new();
    cycle_count   = 0;
    steady        = 1'b0;
    hold_off      = 1'b0;
    stim_done     = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value_bits = 64'd0;
    in_scale      = 32'sd0;
    out_ready     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: signed zeros, infinities, a signalling NaN, subnormal
    // inputs with tiny scales around the cut-off, overflow, deep underflow,
    // subnormal results with ties and a rounding carry into the smallest normal.
    send_beat(64'h0000_0000_0000_0000, 32'sd5);
    send_beat(64'h8000_0000_0000_0000, -32'sd2147483648);
    send_beat(64'h7ff0_0000_0000_0000, -32'sd100);
    send_beat(64'hfff0_0000_0000_0000, 32'sd2147483647);
    send_beat(64'h7ff0_0000_0000_0001, 32'sd0);
    send_beat(64'hffff_ffff_ffff_ffff, 32'sd3);
    send_beat(64'h0000_0000_0000_0001, -32'sd50001);
    send_beat(64'h8000_0000_0000_0001, -32'sd50000);
    send_beat(64'h0000_0000_0000_0001, 32'sd1074);
    send_beat(64'h000f_ffff_ffff_ffff, 32'sd1);
    send_beat(64'h3ff0_0000_0000_0000, 32'sd1023);
    send_beat(64'h3ff0_0000_0000_0000, 32'sd1024);
    send_beat(64'hbff0_0000_0000_0000, 32'sd2147483647);
    send_beat(64'h3ff0_0000_0000_0000, -32'sd1022);
    send_beat(64'h3ff0_0000_0000_0000, -32'sd1074);
    send_beat(64'h3ff8_0000_0000_0000, -32'sd1075);
    send_beat(64'h3ff0_0000_0000_0000, -32'sd1075);
    send_beat(64'h3ff0_0000_0000_0000, -32'sd1076);
    send_beat(64'h3ff0_0000_0000_0000, -32'sd1077);
    send_beat(64'hbfff_ffff_ffff_ffff, -32'sd1023);
    send_beat(64'h3ff8_0000_0000_0000, -32'sd1024);
    send_beat(64'h7fef_ffff_ffff_ffff, -32'sd2147483648);
    send_beat(64'h0010_0000_0000_0000, -32'sd1);
    send_beat(64'h5555_5555_5555_5555, 32'sd0);
    send_beat(64'haaaa_aaaa_aaaa_aaaa, -32'sd1431655766);
    drain();

    for (int unsigned n = 0; n < RandomBeats; n++) begin
      // A stretch without idling on either side.
      steady = (n >= 500 && n < 800);
      // Long receiver hold-off while beats keep coming, so the block fills.
      if (n == 900) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      // Sender pause until everything sent has come back.
      if (n == 1200) drain();
      v = pick_value();
      send_beat(v, pick_scale());
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
